FILE: sv/fh64_pkg.sv
// shared types, constants and codes for the fasthash64 stream block
package fh64_pkg;

  localparam logic [63:0] MUL_M   = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] MUL_MIX = 64'h2127_599b_f432_5c37;
  localparam int unsigned SHIFT_PRE  = 23;
  localparam int unsigned SHIFT_POST = 47;

  // job queue between front and back, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // the 64x64 product is built from three 32x32 partial products
  localparam logic [1:0] MUL_LAST_STEP = 2'd2;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [31:0] msg_length;
  } fh64_in_t;

  typedef struct packed {
    logic [63:0] hash_wide;
    logic [31:0] hash_narrow;
  } fh64_out_t;

  // word already masked and given its first xorshift
  typedef struct packed {
    logic [63:0] word;
    logic        has_bytes;
    logic        first;
    logic        last;
    logic [31:0] len;
  } fh64_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fh64_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_MIX,
    BK_HASH,
    BK_FIN,
    BK_DONE
  } fh64_bstate_t;

  typedef struct packed {
    fh64_bstate_t state;
    logic         slot_free;
  } fh64_bstat_t;

endpackage

FILE: sv/fasthash64_stream.sv
// top level of the streaming fasthash64 block
//
// Input channel: a message arrives as 64-bit words on in_data, byte zero in
// bits 7:0. A transaction completes on a clock edge with push high and full
// low. first_word restarts the hash from the seed and msg_length; last_word
// makes the block emit one result once that word is hashed.
// Result channel: while empty is low, out_data holds the oldest result; it
// is taken on an edge with pop high. A waiting result does not block the
// next words: they queue and are hashed until the next result is ready.
// Configuration: cfg_we writes cfg_wdata into the seed register; write it
// only while no message is in flight.
// Hashing: every 64-bit product is built from three 32x32 partial
// products on one shared multiplier; a middle word needs a mix and a hash
// product, a first word also a length product, a last word also the finalising mix.
// A result reaches the result register once its last word is finalised
// and the result register is free.
// Reset: synchronous, active low; seed and running hash go to zero and
// the job queue and result register are emptied. A result stays on out_data
// until popped; with both queue entries taken, full rises and holds the input.
module fasthash64_stream (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  fh64_pkg::fh64_in_t   in_data,
  output logic                 empty,
  input  logic                 pop,
  output fh64_pkg::fh64_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_wdata
);

  logic [63:0]           seed_r, seed_nxt;
  fh64_pkg::fh64_job_t   front_job, head_job;
  fh64_pkg::fh64_qstat_t q_stat;
  fh64_pkg::fh64_bstat_t bk_stat;
  logic                  q_push, q_pop;

  assign seed_nxt = cfg_we ? cfg_wdata : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  fh64_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .job     (front_job)
  );

  fh64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  fh64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .job_valid (!q_stat.empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .stat      (bk_stat)
  );

`ifndef SYNTH
  // a finished hash reaches the result register once the slot frees
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.state == fh64_pkg::BK_DONE && bk_stat.slot_free) |=> !empty)
    else $error("finished hash not loaded into result register");

  // an accepted transaction is held in the job queue on the next cycle
  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !q_stat.empty)
    else $error("accepted word missing from job queue");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue both full and empty");

  // the back end only takes a job when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (bk_stat.state == fh64_pkg::BK_IDLE && !q_stat.empty))
    else $error("job taken while back end busy");
`endif

endmodule

FILE: sv/fh64_front.sv
// front end: input handshake, byte masking and first xorshift of each word
module fh64_front (
  input  logic               push,
  output logic               full,
  input  fh64_pkg::fh64_in_t in_data,
  input  fh64_pkg::fh64_qstat_t q_stat,
  output logic               q_push,
  output fh64_pkg::fh64_job_t job
);

  logic [63:0] masked;

  assign full   = q_stat.full;
  assign q_push = push && !q_stat.full;

  // byte i is kept when the count exceeds i; counts above eight keep all
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (in_data.valid_bytes > 4'(i)) ? in_data.data_word[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    job.word      = masked ^ (masked >> fh64_pkg::SHIFT_PRE);
    job.has_bytes = (in_data.valid_bytes != 4'd0);
    job.first     = in_data.first_word;
    job.last      = in_data.last_word;
    job.len       = in_data.msg_length;
  end

endmodule

FILE: sv/fh64_queue.sv
// short job queue between front and back
module fh64_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fh64_pkg::fh64_job_t   push_job,
  input  logic                  pop,
  output fh64_pkg::fh64_job_t   head_job,
  output fh64_pkg::fh64_qstat_t stat
);

  fh64_pkg::fh64_job_t               mem_r [fh64_pkg::QUEUE_DEPTH];
  logic [fh64_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [fh64_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [fh64_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_push, do_pop;

  assign stat.full  = (count_r == fh64_pkg::QCNT_W'(fh64_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: sv/fh64_back.sv
// back end: hash recurrence on a shared 32x32 multiplier, finalisation, result register
module fh64_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [63:0]          seed,
  input  logic                 job_valid,
  input  fh64_pkg::fh64_job_t  job,
  output logic                 job_pop,
  output logic                 empty,
  input  logic                 pop,
  output fh64_pkg::fh64_out_t  out_data,
  output fh64_pkg::fh64_bstat_t stat
);

  fh64_pkg::fh64_bstate_t state_r, state_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [63:0]            mul_a_r, mul_a_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [63:0]            h_r, h_nxt;
  logic [63:0]            res_r, res_nxt;
  fh64_pkg::fh64_job_t    cur_r, cur_nxt;
  fh64_pkg::fh64_out_t    out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [63:0] mul_c;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;
  logic [63:0] acc_fin;
  logic [63:0] seeded, mixed;
  logic        mul_busy, mul_done, slot_free, load_out;

  assign mul_busy  = (state_r == fh64_pkg::BK_LEN) || (state_r == fh64_pkg::BK_MIX) ||
                     (state_r == fh64_pkg::BK_HASH) || (state_r == fh64_pkg::BK_FIN);
  assign mul_done  = mul_busy && (step_r == fh64_pkg::MUL_LAST_STEP);
  assign slot_free = !out_valid_r || pop;

  assign mul_c = ((state_r == fh64_pkg::BK_MIX) || (state_r == fh64_pkg::BK_FIN)) ?
                 fh64_pkg::MUL_MIX : fh64_pkg::MUL_M;

  // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo into the upper half
  assign op_x = (step_r == fh64_pkg::MUL_LAST_STEP) ? mul_a_r[63:32] : mul_a_r[31:0];
  assign op_y = (step_r == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign prod = 64'(op_x) * 64'(op_y);

  assign acc_fin = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
  assign seeded  = seed ^ acc_fin;
  assign mixed   = acc_fin ^ (acc_fin >> fh64_pkg::SHIFT_POST);

  always_comb begin
    step_nxt = '0;
    if (mul_busy && !mul_done) begin
      step_nxt = step_r + 2'd1;
    end
    acc_nxt = (step_r == 2'd0) ? prod : acc_fin;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fh64_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (job.first) begin
            state_nxt = fh64_pkg::BK_LEN;
          end else if (job.has_bytes) begin
            state_nxt = fh64_pkg::BK_MIX;
          end else if (job.last) begin
            state_nxt = fh64_pkg::BK_FIN;
          end
        end
      end
      fh64_pkg::BK_LEN: begin
        if (mul_done) begin
          if (cur_r.has_bytes) begin
            state_nxt = fh64_pkg::BK_MIX;
          end else if (cur_r.last) begin
            state_nxt = fh64_pkg::BK_FIN;
          end else begin
            state_nxt = fh64_pkg::BK_IDLE;
          end
        end
      end
      fh64_pkg::BK_MIX: begin
        if (mul_done) begin
          state_nxt = fh64_pkg::BK_HASH;
        end
      end
      fh64_pkg::BK_HASH: begin
        if (mul_done) begin
          state_nxt = cur_r.last ? fh64_pkg::BK_FIN : fh64_pkg::BK_IDLE;
        end
      end
      fh64_pkg::BK_FIN: begin
        if (mul_done) begin
          state_nxt = fh64_pkg::BK_DONE;
        end
      end
      fh64_pkg::BK_DONE: begin
        if (slot_free) begin
          state_nxt = fh64_pkg::BK_IDLE;
        end
      end
      default: state_nxt = fh64_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    h_nxt     = h_r;
    mul_a_nxt = mul_a_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    job_pop   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      fh64_pkg::BK_IDLE: begin
        job_pop = job_valid;
        cur_nxt = job;
        if (job.first) begin
          mul_a_nxt = {32'h0, job.len};
        end else if (job.has_bytes) begin
          mul_a_nxt = job.word;
        end else begin
          mul_a_nxt = h_r ^ (h_r >> fh64_pkg::SHIFT_PRE);
        end
      end
      fh64_pkg::BK_LEN: begin
        if (mul_done) begin
          h_nxt     = seeded;
          mul_a_nxt = cur_r.has_bytes ? cur_r.word : seeded ^ (seeded >> fh64_pkg::SHIFT_PRE);
        end
      end
      fh64_pkg::BK_MIX: begin
        if (mul_done) begin
          mul_a_nxt = h_r ^ mixed;
        end
      end
      fh64_pkg::BK_HASH: begin
        if (mul_done) begin
          h_nxt     = acc_fin;
          mul_a_nxt = acc_fin ^ (acc_fin >> fh64_pkg::SHIFT_PRE);
        end
      end
      fh64_pkg::BK_FIN: begin
        if (mul_done) begin
          res_nxt = mixed;
        end
      end
      fh64_pkg::BK_DONE: begin
        load_out = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = load_out || (out_valid_r && !pop);
    out_nxt       = out_r;
    if (load_out) begin
      out_nxt.hash_wide   = res_r;
      out_nxt.hash_narrow = res_r[31:0] - res_r[63:32];
    end
  end

  assign empty          = !out_valid_r;
  assign out_data       = out_r;
  assign stat.state     = state_r;
  assign stat.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fh64_pkg::BK_IDLE;
      step_r      <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r <= mul_a_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    cur_r   <= cur_nxt;
    out_r   <= out_nxt;
  end

endmodule
